### rtl/core/prf_pkg.sv
// prf_pkg: shared types and constants for the png row filter selector
// used by prf_front, prf_filter, prf_back and png_row_filter_select
`default_nettype none

package prf_pkg;

  localparam int DEF_MAX_ROW_BYTES = 8192;

  localparam int ROW_BYTES_W = 14;
  localparam int BPP_W       = 4;
  localparam int CFG_DATA_W  = 14;
  localparam int CFG_IDX_W   = 1;

  localparam logic [ROW_BYTES_W-1:0] DEF_ROW_BYTES = 14'd8;
  localparam logic [BPP_W-1:0]       DEF_BPP       = 4'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 1'b1;

  localparam int NUM_FILTERS = 5;
  localparam int SUM_W       = 21;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // left neighbour history covers every 4-bit pixel distance
  localparam int HIST_DEPTH = 15;
  localparam int HIST_IDX_W = 4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef enum logic [0:0] {
    OP_PUSH = 1'b0,
    OP_PULL = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       new_image;
  } cmd_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       is_type_byte;
    logic       last_of_row;
  } res_t;

  typedef logic [NUM_FILTERS-1:0][7:0] filt_vec_t;

endpackage

`default_nettype wire

### rtl/core/prf_front.sv
// prf_front: accepts request transactions, tags push or pull, and queues them
// depends on prf_pkg
`default_nettype none

module prf_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,   // data_byte
  input  wire logic [1:0]    s_tuser,   // req_type, new_image
  output logic               q_valid,
  output prf_pkg::cmd_t      q_cmd,
  input  wire logic          q_pop
);
  import prf_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  cmd_t              cmd_in;

  assign s_tready = (count != (QPTR_W+1)'(QUEUE_DEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != '0);
  assign q_cmd    = entries[rd_ptr];

  always_comb begin
    cmd_in.op        = s_tuser[0] ? OP_PULL : OP_PUSH;
    cmd_in.data      = s_tdata;
    cmd_in.new_image = s_tuser[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (q_pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !q_pop) count <= count + (QPTR_W+1)'(1);
      else if (!push && q_pop) count <= count - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= cmd_in;
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> count != '0)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

### rtl/core/prf_filter.sv
// prf_filter: forms the five png filter values of one byte from its neighbours
// depends on prf_pkg
`default_nettype none

module prf_filter (
  input  wire logic [7:0]   x,
  input  wire logic [7:0]   left,
  input  wire logic [7:0]   up,
  input  wire logic [7:0]   corner,
  output prf_pkg::filt_vec_t filt
);
  import prf_pkg::*;

  logic signed [10:0] pa_s;
  logic signed [10:0] pb_s;
  logic signed [10:0] pc_s;
  logic [9:0]         pa;
  logic [9:0]         pb;
  logic [9:0]         pc;
  logic [7:0]         pred;
  logic [8:0]         avg_sum;

  always_comb begin
    pa_s = $signed({3'b000, up}) - $signed({3'b000, corner});
    pb_s = $signed({3'b000, left}) - $signed({3'b000, corner});
    pc_s = $signed({3'b000, left}) + $signed({3'b000, up})
         - $signed({2'b00, corner, 1'b0});
    pa = pa_s[10] ? 10'(-pa_s) : 10'(pa_s);
    pb = pb_s[10] ? 10'(-pb_s) : 10'(pb_s);
    pc = pc_s[10] ? 10'(-pc_s) : 10'(pc_s);
    if (pa <= pb && pa <= pc) pred = left;
    else if (pb <= pc)        pred = up;
    else                      pred = corner;
    avg_sum = {1'b0, left} + {1'b0, up};

    filt[FILT_NONE]  = x;
    filt[FILT_SUB]   = x - left;
    filt[FILT_UP]    = x - up;
    filt[FILT_AVG]   = x - avg_sum[8:1];
    filt[FILT_PAETH] = x - pred;
  end

endmodule

`default_nettype wire

### rtl/core/prf_back.sv
// prf_back: row stores, filter sums, minimum search and row drain sequencer
// depends on prf_pkg and prf_filter
`default_nettype none

module prf_back #(
  parameter int MAX_ROW_BYTES = prf_pkg::DEF_MAX_ROW_BYTES,
  parameter int CNT_W         = $clog2(MAX_ROW_BYTES + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [CNT_W-1:0]          row_len,
  input  wire logic [prf_pkg::BPP_W-1:0] pix_dist,
  input  wire logic                      q_valid,
  input  wire prf_pkg::cmd_t             q_cmd,
  output logic                           q_pop,
  output logic                           m_valid,
  output prf_pkg::res_t                  m_res,
  input  wire logic                      m_ready
);
  import prf_pkg::*;

  localparam int ADDR_W = $clog2(MAX_ROW_BYTES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILT,
    S_SUM,
    S_SELECT,
    S_EMIT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] drain_index;
  logic             row_ready;
  logic             prior_select;
  logic             prior_is_zero;
  logic [SUM_W-1:0] sums [NUM_FILTERS];
  logic [2:0]       chosen;
  logic [2:0]       sel_idx;
  logic [2:0]       best_idx;
  logic [SUM_W-1:0] best_sum;

  logic [7:0]       mem_a [MAX_ROW_BYTES];
  logic [7:0]       mem_b [MAX_ROW_BYTES];
  logic [7:0]       rd_a;
  logic [7:0]       rd_b;
  logic [7:0]       hist_cur [HIST_DEPTH];
  logic [7:0]       hist_pri [HIST_DEPTH];
  cmd_t             cmd_q;
  logic             has_left;
  filt_vec_t        filt_q;
  res_t             res;

  logic             take;
  logic             mem_we;
  logic             out_free;
  logic [CNT_W-1:0] drain_prev;
  logic [CNT_W-1:0] pos;
  logic [ADDR_W-1:0] addr;
  logic [CNT_W-1:0] fill_next;
  logic [HIST_IDX_W-1:0] d_idx;
  logic [7:0]       cur_rd;
  logic [7:0]       pri_rd;
  logic [7:0]       x_val;
  logic [7:0]       left_val;
  logic [7:0]       up_val;
  logic [7:0]       corner_val;
  filt_vec_t        filt;
  logic [7:0]       sel_byte;
  logic             drain_last;
  logic [7:0]       mag [NUM_FILTERS];
  logic [SUM_W:0]   sum_ext [NUM_FILTERS];
  logic [SUM_W-1:0] sum_new [NUM_FILTERS];
  logic [SUM_W-1:0] cand;
  logic             lower;

  assign take       = (state == S_IDLE) && q_valid;
  assign q_pop      = take;
  assign mem_we     = take && (q_cmd.op == OP_PUSH) && !row_ready;
  assign out_free   = !m_valid || m_ready;
  assign drain_prev = drain_index - CNT_W'(1);
  assign pos        = (q_cmd.op == OP_PUSH) ? fill_count : drain_prev;
  assign addr       = pos[ADDR_W-1:0];
  assign fill_next  = fill_count + CNT_W'(1);
  assign d_idx      = pix_dist - HIST_IDX_W'(1);
  assign cur_rd     = prior_select ? rd_a : rd_b;
  assign pri_rd     = prior_select ? rd_b : rd_a;
  assign x_val      = (cmd_q.op == OP_PUSH) ? cmd_q.data : cur_rd;
  assign left_val   = has_left ? hist_cur[d_idx] : 8'd0;
  assign up_val     = prior_is_zero ? 8'd0 : pri_rd;
  assign corner_val = (has_left && !prior_is_zero) ? hist_pri[d_idx] : 8'd0;
  assign drain_last = (drain_index >= fill_count);
  assign cand       = sums[sel_idx];
  assign lower      = (cand < best_sum);

  prf_filter u_filter (
    .x      (x_val),
    .left   (left_val),
    .up     (up_val),
    .corner (corner_val),
    .filt   (filt)
  );

  always_comb begin
    case (chosen)
      FILT_NONE:  sel_byte = filt[FILT_NONE];
      FILT_SUB:   sel_byte = filt[FILT_SUB];
      FILT_UP:    sel_byte = filt[FILT_UP];
      FILT_AVG:   sel_byte = filt[FILT_AVG];
      FILT_PAETH: sel_byte = filt[FILT_PAETH];
      default:    sel_byte = filt[FILT_NONE];
    endcase
  end

  // magnitude of each filtered byte read as signed, saturating sums
  always_comb begin
    for (int t = 0; t < NUM_FILTERS; t++) begin
      mag[t]     = filt_q[t][7] ? (~filt_q[t] + 8'd1) : filt_q[t];
      sum_ext[t] = {1'b0, sums[t]} + (SUM_W+1)'(mag[t]);
      sum_new[t] = sum_ext[t][SUM_W] ? SUM_MAX : sum_ext[t][SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we && prior_select) mem_a[addr] <= q_cmd.data;
    if (take) rd_a <= mem_a[addr];
  end

  always_ff @(posedge clk) begin
    if (mem_we && !prior_select) mem_b[addr] <= q_cmd.data;
    if (take) rd_b <= mem_b[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      fill_count    <= '0;
      drain_index   <= '0;
      row_ready     <= 1'b0;
      prior_select  <= 1'b0;
      prior_is_zero <= 1'b1;
      chosen        <= FILT_NONE;
      sel_idx       <= '0;
      best_idx      <= '0;
      best_sum      <= '0;
      m_valid       <= 1'b0;
      for (int t = 0; t < NUM_FILTERS; t++) sums[t] <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_cmd.op == OP_PUSH) begin
              if (!row_ready) begin
                if (fill_count == '0 && q_cmd.new_image) prior_is_zero <= 1'b1;
                state <= S_FILT;
              end
            end else begin
              if (row_ready && drain_index == '0) drain_index <= CNT_W'(1);
              if (row_ready && drain_index != '0) state <= S_FILT;
              else state <= S_EMIT;
            end
          end
        end
        S_FILT: begin
          if (cmd_q.op == OP_PUSH) begin
            state <= S_SUM;
          end else begin
            if (drain_last) begin
              row_ready     <= 1'b0;
              drain_index   <= '0;
              fill_count    <= '0;
              prior_select  <= !prior_select;
              prior_is_zero <= 1'b0;
              for (int t = 0; t < NUM_FILTERS; t++) sums[t] <= '0;
            end else begin
              drain_index <= drain_index + CNT_W'(1);
            end
            state <= S_EMIT;
          end
        end
        S_SUM: begin
          for (int t = 0; t < NUM_FILTERS; t++) sums[t] <= sum_new[t];
          fill_count <= fill_next;
          if (fill_next >= row_len) begin
            sel_idx  <= FILT_SUB;
            best_idx <= FILT_NONE;
            best_sum <= sum_new[FILT_NONE];
            state    <= S_SELECT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SELECT: begin
          if (sel_idx == 3'(NUM_FILTERS - 1)) begin
            chosen      <= lower ? sel_idx : best_idx;
            row_ready   <= 1'b1;
            drain_index <= '0;
            state       <= S_IDLE;
          end else begin
            if (lower) begin
              best_idx <= sel_idx;
              best_sum <= cand;
            end
            sel_idx <= sel_idx + 3'd1;
          end
        end
        S_EMIT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      if (state == S_EMIT && out_free) m_valid <= 1'b1;
      else if (m_ready) m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_q    <= q_cmd;
      has_left <= (pos >= CNT_W'(pix_dist));
      if (row_ready) begin
        res <= '{out_valid: 1'b1, out_byte: {5'b00000, chosen}, is_type_byte: 1'b1,
                 last_of_row: 1'b0};
      end else begin
        res <= '0;
      end
    end
    if (state == S_FILT) begin
      hist_cur[0] <= x_val;
      hist_pri[0] <= pri_rd;
      for (int j = 1; j < HIST_DEPTH; j++) begin
        hist_cur[j] <= hist_cur[j-1];
        hist_pri[j] <= hist_pri[j-1];
      end
      if (cmd_q.op == OP_PUSH) begin
        filt_q <= filt;
      end else begin
        res <= '{out_valid: 1'b1, out_byte: sel_byte, is_type_byte: 1'b0,
                 last_of_row: drain_last};
      end
    end
    if (state == S_EMIT && out_free) m_res <= res;
  end

  a_ready_has_bytes: assert property (@(posedge clk) disable iff (rst)
    row_ready |-> fill_count != '0)
    else $error("finished row holds no bytes");

  a_drain_in_row: assert property (@(posedge clk) disable iff (rst)
    row_ready |-> drain_index <= fill_count)
    else $error("drain index beyond row");

  a_no_write_ready: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !row_ready)
    else $error("row store written while a row waits");

  a_chosen_range: assert property (@(posedge clk) disable iff (rst)
    row_ready |-> chosen <= 3'(NUM_FILTERS - 1))
    else $error("chosen filter out of range");

  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    (m_valid && m_res.last_of_row) |-> m_res.out_valid && !m_res.is_type_byte)
    else $error("row end on an empty or type byte");

endmodule

`default_nettype wire

### rtl/core/png_row_filter_select.sv
// png_row_filter_select: top level, configuration registers and stream packing
// depends on prf_pkg, prf_front and prf_back
//
//   channel   direction  handshake           payload
//   s_*       in         s_tvalid/s_tready   s_tdata data_byte, s_tuser req_type,new_image
//   m_*       out        m_tvalid/m_tready   m_tdata out_valid,out_byte, m_tuser, m_tlast
//   cfg_*     in         cfg_we              cfg_index, cfg_data
//
// a push passes the back end through a store read, the filter and a sum update; the
// push that completes a row adds the minimum search, one compare per cycle
// a pull sends an empty or type byte straight on, and a filtered byte after the
// registered row store read and the filter; a 4-entry queue decouples the input side
// the row stores need no clearing pass after reset; a stalled m_tready holds the
// result register, the back end then waits and the queue fills before s_tready drops
`default_nettype none

module png_row_filter_select #(
  parameter int MAX_ROW_BYTES = prf_pkg::DEF_MAX_ROW_BYTES
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [7:0]                     s_tdata,   // data_byte
  input  wire logic [1:0]                     s_tuser,   // req_type, new_image
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [15:0]                         m_tdata,   // out_valid, out_byte, zero fill
  output logic [0:0]                          m_tuser,   // is_type_byte
  output logic                                m_tlast,
  input  wire logic                           cfg_we,
  input  wire logic [prf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [prf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import prf_pkg::*;

  localparam int CNT_W = $clog2(MAX_ROW_BYTES + 1);
  localparam int LEN_W = (CNT_W > ROW_BYTES_W) ? CNT_W : ROW_BYTES_W;

  logic [ROW_BYTES_W-1:0] row_bytes;
  logic [BPP_W-1:0]       bytes_per_pixel;
  logic [LEN_W-1:0]       rb_ext;
  logic [CNT_W-1:0]       row_len;
  logic [BPP_W-1:0]       pix_dist;
  logic                   q_valid;
  cmd_t                   q_cmd;
  logic                   q_pop;
  res_t                   m_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes       <= DEF_ROW_BYTES;
      bytes_per_pixel <= DEF_BPP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW_BYTES:       row_bytes       <= cfg_data[ROW_BYTES_W-1:0];
        CFG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_data[BPP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rb_ext = LEN_W'(row_bytes);
    if (rb_ext == '0) row_len = CNT_W'(1);
    else if (rb_ext > LEN_W'(MAX_ROW_BYTES)) row_len = CNT_W'(MAX_ROW_BYTES);
    else row_len = CNT_W'(rb_ext);
    pix_dist = (bytes_per_pixel == '0) ? BPP_W'(1) : bytes_per_pixel;
  end

  prf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  prf_back #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES),
    .CNT_W         (CNT_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .row_len  (row_len),
    .pix_dist (pix_dist),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .m_valid  (m_tvalid),
    .m_res    (m_res),
    .m_ready  (m_tready)
  );

  assign m_tdata = {7'b0000000, m_res.out_byte, m_res.out_valid};
  assign m_tuser = m_res.is_type_byte;
  assign m_tlast = m_res.last_of_row;

endmodule

`default_nettype wire

### tb/tb.sv
// tb: self-checking bench for png_row_filter_select, rows pushed and drained over the streams
// a scoreboard class predicts every pulled byte from its own row stores and filter sums
// depends on prf_pkg and the png_row_filter_select rtl
module tb;
  import prf_pkg::*;

  class row_filter_scoreboard;
    logic [ROW_BYTES_W-1:0] row_bytes_reg;
    logic [BPP_W-1:0]       bpp_reg;
    logic [7:0]             store_a [DEF_MAX_ROW_BYTES];
    logic [7:0]             store_b [DEF_MAX_ROW_BYTES];
    bit                     prior_sel;
    bit                     prior_zero;
    bit                     row_done;
    int                     fill;
    int                     drain;
    int                     ext_a;
    int                     ext_b;
    int                     errors;
    logic [SUM_W-1:0]       sums [NUM_FILTERS];
    filt_t                  chosen;
    res_t                   expected_bytes[$];

    function new();
      row_bytes_reg = DEF_ROW_BYTES;
      bpp_reg       = DEF_BPP;
      prior_sel     = 0;
      prior_zero    = 1;
      row_done      = 0;
      fill          = 0;
      drain         = 0;
      ext_a         = 0;
      ext_b         = 0;
      errors        = 0;
      chosen        = FILT_NONE;
      foreach (sums[t]) sums[t] = '0;
      foreach (store_a[k]) begin
        store_a[k] = '0;
        store_b[k] = '0;
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_ROW_BYTES) begin
        row_bytes_reg = value[ROW_BYTES_W-1:0];
      end else begin
        bpp_reg = value[BPP_W-1:0];
      end
    endfunction

    function int row_length();
      if (row_bytes_reg == 0) return 1;
      if (int'(row_bytes_reg) > DEF_MAX_ROW_BYTES) return DEF_MAX_ROW_BYTES;
      return int'(row_bytes_reg);
    endfunction

    function int distance();
      return (bpp_reg == 0) ? 1 : int'(bpp_reg);
    endfunction

    function int cur_byte(int i);
      return prior_sel ? int'(store_a[i]) : int'(store_b[i]);
    endfunction

    function int prior_byte(int i);
      if (prior_zero) return 0;
      return prior_sel ? int'(store_b[i]) : int'(store_a[i]);
    endfunction

    function int prior_extent();
      return prior_sel ? ext_b : ext_a;
    endfunction

    function int dist_of(int u, int v);
      return (u > v) ? u - v : v - u;
    endfunction

    function logic [7:0] filtered_byte(int i, filt_t f);
      int d, x, a, b, c, p, pa, pb, pc;
      d = distance();
      x = cur_byte(i);
      a = (i >= d) ? cur_byte(i - d) : 0;
      b = prior_byte(i);
      c = (i >= d) ? prior_byte(i - d) : 0;
      case (f)
        FILT_SUB: p = a;
        FILT_UP:  p = b;
        FILT_AVG: p = (a + b) / 2;
        FILT_PAETH: begin
          pa = dist_of(b, c);
          pb = dist_of(a, c);
          pc = dist_of(a + b, 2 * c);
          if (pa <= pb && pa <= pc) p = a;
          else if (pb <= pc) p = b;
          else p = c;
        end
        default: p = 0;
      endcase
      return 8'(x - p);
    endfunction

    function void take_item(cmd_t c);
      logic [7:0] v;
      int mag, s;
      res_t r;
      if (c.op == OP_PUSH) begin
        if (row_done) return;
        if (fill == 0 && c.new_image) prior_zero = 1;
        if (prior_sel) begin
          store_a[fill] = c.data;
          if (fill >= ext_a) ext_a = fill + 1;
        end else begin
          store_b[fill] = c.data;
          if (fill >= ext_b) ext_b = fill + 1;
        end
        for (int t = 0; t < NUM_FILTERS; t++) begin
          v   = filtered_byte(fill, filt_t'(t));
          mag = (v >= 128) ? 256 - int'(v) : int'(v);
          s   = int'(sums[t]) + mag;
          sums[t] = (s > int'(SUM_MAX)) ? SUM_MAX : SUM_W'(s);
        end
        fill++;
        if (fill >= row_length()) begin
          chosen = FILT_NONE;
          for (int t = 1; t < NUM_FILTERS; t++)
            if (sums[t] < sums[int'(chosen)]) chosen = filt_t'(t);
          row_done = 1;
          drain    = 0;
        end
      end else begin
        r = '0;
        if (row_done) begin
          r.out_valid = 1'b1;
          if (drain == 0) begin
            r.out_byte     = 8'(chosen);
            r.is_type_byte = 1'b1;
            drain          = 1;
          end else begin
            r.out_byte = filtered_byte(drain - 1, chosen);
            if (drain >= fill) begin
              r.last_of_row = 1'b1;
              row_done      = 0;
              drain         = 0;
              fill          = 0;
              prior_sel     = !prior_sel;
              prior_zero    = 0;
              foreach (sums[t]) sums[t] = '0;
            end else begin
              drain++;
            end
          end
        end
        expected_bytes = {expected_bytes, r};
      end
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_byte(res_t got);
      res_t want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("transaction with nothing expected, byte %02h", got.out_byte));
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_valid !== want.out_valid)
        report($sformatf("out_valid %b, expected %b", got.out_valid, want.out_valid));
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte %02h, expected %02h", got.out_byte, want.out_byte));
      if (got.is_type_byte !== want.is_type_byte)
        report($sformatf("is_type_byte %b, expected %b", got.is_type_byte, want.is_type_byte));
      if (got.last_of_row !== want.last_of_row)
        report($sformatf("last_of_row %b, expected %b", got.last_of_row, want.last_of_row));
    endtask
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata   = '0;    // data_byte
  logic [1:0]            s_tuser   = '0;    // req_type, new_image
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [15:0]           m_tdata;           // out_valid, out_byte, zero fill
  logic [0:0]            m_tuser;           // is_type_byte
  logic                  m_tlast;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_ROW_BYTES;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  row_filter_scoreboard sb;
  int gap_mode    = 1;
  int stall_mode  = 1;
  int stall_left  = 0;
  int row_pattern = 0;
  int pattern_base = 0;
  int pattern_step = 0;
  int counted     = 0;

  always #2 clk = ~clk;

  png_row_filter_select i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic int pick_idle(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (mode == 1) begin
      if (r < 60) return 0;
      if (r < 96) return $urandom_range(1, 3);
      return $urandom_range(12, 40);
    end
    if (r < 25) return 0;
    if (r < 88) return $urandom_range(1, 4);
    return $urandom_range(12, 40);
  endfunction

  // result side: check each transaction, then pick the next stall
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_byte({m_tdata[0], m_tdata[8:1], m_tuser[0], m_tlast});
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      stall_left = pick_idle(stall_mode);
      m_tready <= (stall_left == 0);
    end
  end

  task automatic send(cmd_t c);
    int gap;
    gap = pick_idle(gap_mode);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c.data;
    s_tuser  <= {c.new_image, c.op};
    do @(posedge clk); while (!s_tready);
    sb.take_item(c);
    counted++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  function automatic logic [7:0] row_byte(int i);
    int d, left;
    d    = sb.distance();
    left = (i >= d) ? sb.cur_byte(i - d) : 0;
    case (row_pattern)
      1: return 8'(pattern_base);
      2: return 8'(sb.prior_byte(i) + $urandom_range(0, 2) - 1);
      3: return 8'(pattern_base + i * pattern_step);
      4: begin
        case ($urandom_range(0, 3))
          0:       return 8'h00;
          1:       return 8'hff;
          2:       return 8'h7f;
          default: return 8'h80;
        endcase
      end
      5: return (i >= d) ? 8'(left + $urandom_range(0, 2) - 1) : 8'($urandom);
      6: return 8'((left + sb.prior_byte(i)) / 2 + $urandom_range(0, 1));
      7: return 8'(sb.prior_byte(i) + left - ((i >= d) ? sb.prior_byte(i - d) : 0));
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly well-formed rows; loose mode adds pulls on an empty block and pushes that get dropped
  task automatic make_item(input bit tight, output cmd_t c, output bit ignored);
    int r;
    r = $urandom_range(0, 99);
    c.new_image = 1'($urandom_range(0, 1));
    c.data      = 8'($urandom);
    if (sb.row_done) c.op = (tight || r < 92) ? OP_PULL : OP_PUSH;
    else c.op = (!tight && r < 10) ? OP_PULL : OP_PUSH;
    ignored = (c.op == OP_PUSH && sb.row_done);
    if (c.op == OP_PULL || ignored) return;
    if (sb.fill == 0) begin
      c.new_image = ($urandom_range(0, 99) < 25);
      // prior row too short to be read: start a new image instead
      if (!sb.prior_zero && sb.row_length() > sb.prior_extent()) c.new_image = 1'b1;
      row_pattern  = $urandom_range(0, 7);
      pattern_base = $urandom_range(0, 255);
      pattern_step = $urandom_range(0, 8);
    end else begin
      c.new_image = ($urandom_range(0, 99) < 10);
    end
    c.data = row_byte(sb.fill);
  endtask

  task automatic finish_row();
    cmd_t c;
    bit   ign;
    while (sb.fill != 0 || sb.row_done) begin
      make_item(1'b1, c, ign);
      send(c);
    end
  endtask

  task automatic new_phase(int phase);
    int fixed_len [4] = '{1, 0, 3, 16};
    int fixed_bpp [4] = '{1, 0, 15, 8};
    int len, bpp, r;
    bit set_len, set_bpp;
    r = $urandom_range(0, 99);
    set_len = (phase < 4) || ($urandom_range(0, 1) == 1);
    set_bpp = (phase < 4) || ($urandom_range(0, 1) == 1);
    if (phase < 4) begin
      len = fixed_len[phase];
      bpp = fixed_bpp[phase];
    end else begin
      len = (r < 55) ? $urandom_range(1, 16) : (r < 72) ? $urandom_range(17, 64) :
            (r < 82) ? 0 : $urandom_range(65, 300);
      bpp = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 4) : $urandom_range(0, 15);
    end
    // row length changes only between rows
    if (set_len) finish_row();
    settle();
    if (set_len) cfg_write(CFG_ROW_BYTES, CFG_DATA_W'(len));
    if (set_bpp) cfg_write(CFG_BYTES_PER_PIXEL, {10'($urandom), 4'(bpp)});
    gap_mode   = $urandom_range(0, 2);
    stall_mode = $urandom_range(0, 2);
  endtask

  initial begin
    logic [7:0] dir_bytes [8] = '{8'h00, 8'hff, 8'h80, 8'h7f, 8'h01, 8'hfe, 8'h55, 8'haa};
    cmd_t c;
    bit   ign;
    int   phase;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: 8 byte rows, 4 bytes per pixel
    send('{OP_PULL, 8'h00, 1'b0});
    for (int k = 0; k < 8; k++)
      send('{OP_PUSH, dir_bytes[k], (k == 0 || k == 4)});
    send('{OP_PUSH, 8'h3c, 1'b1});
    for (int k = 0; k < 9; k++)
      send('{OP_PULL, 8'hff, 1'b1});
    send('{OP_PULL, 8'h00, 1'b0});
    settle();

    phase = 0;
    while (counted < 900) begin
      new_phase(phase);
      phase++;
      repeat ($urandom_range(30, 120)) begin
        make_item(1'b0, c, ign);
        send(c);
      end
    end
    settle();

    if (sb.errors == 0 && sb.expected_bytes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### png_row_filter_select.f
rtl/core/prf_pkg.sv
rtl/core/prf_front.sv
rtl/core/prf_filter.sv
rtl/core/prf_back.sv
rtl/core/png_row_filter_select.sv
tb/tb.sv
